FILE: rtl/core/icodir_pkg.sv
// Shared types and constants for the icon directory parser.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package icodir_pkg;

    localparam int unsigned MAX_ENTRIES = 256;
    localparam int unsigned HDR_BYTES   = 6;
    localparam int unsigned ENT_BYTES   = 16;

    localparam logic [15:0] TYPE_ICON   = 16'd1;
    localparam logic [15:0] TYPE_CURSOR = 16'd2;

    localparam logic [20:0] BONUS_ALPHA = 21'd1000000;
    localparam logic [20:0] BONUS_TRUE  = 21'd500000;
    localparam logic [20:0] BONUS_INDEX = 21'd100000;
    localparam logic [8:0]  DIM_FULL    = 9'd256;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNCATED = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_COUNT     = 3'd3,
        ST_CORRUPT   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_ENTRIES = 3'b010,
        PH_DONE    = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  pick_index;
        logic [8:0]  sel_width;
        logic [8:0]  sel_height;
        logic [15:0] pix_depth;
        logic [8:0]  dir_count;
        logic [31:0] img_len;
        logic [31:0] entry_offset;
        logic        is_cursor;
        logic        indexed;
        logic        alpha_flag;
    } result_t;

endpackage

FILE: rtl/core/icodir_in_reg.sv
// Input register for byte transactions.
// Depends on icodir_pkg (item_t).
`timescale 1ns / 1ps

module icodir_in_reg
    import icodir_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: rtl/core/icodir_parser.sv
// Header/entry parser, entry scoring and best-entry tracking.
// Depends on icodir_pkg (types, status codes, score constants).
`timescale 1ns / 1ps

module icodir_parser
    import icodir_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    input  item_t       item,
    input  logic        out_free,
    output logic        take,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg,      phase_next;
    logic [3:0]  cnt_reg,        cnt_next;
    logic [7:0]  stage_reg [0:ENT_BYTES-2];
    logic        cursor_reg,     cursor_next;
    logic [8:0]  total_reg,      total_next;
    logic [8:0]  num_reg,        num_next;
    logic [20:0] best_score_reg, best_score_next;
    logic [7:0]  best_index_reg, best_index_next;
    logic [8:0]  best_w_reg,     best_w_next;
    logic [8:0]  best_h_reg,     best_h_next;
    logic [15:0] best_bpp_reg,   best_bpp_next;
    logic [31:0] best_bytes_reg, best_bytes_next;
    logic [31:0] best_off_reg,   best_off_next;
    logic [31:0] file_size_reg;

    // header fields; the count's top byte is the incoming one
    logic [15:0] hdr_rsv, hdr_type, hdr_count;
    // entry fields; the offset's top byte is the incoming one
    logic [8:0]  ent_w, ent_h;
    logic [15:0] ent_bc;
    logic [31:0] ent_bytes, ent_off;
    logic [32:0] ent_end;
    logic [17:0] ent_area;
    logic [20:0] ent_score;
    logic [8:0]  num_inc;

    logic        hdr_end, ent_end_byte, active;
    logic        emit;
    status_t     st;
    logic        ent_better;

    always_comb begin
        hdr_rsv   = {stage_reg[1], stage_reg[0]};
        hdr_type  = {stage_reg[3], stage_reg[2]};
        hdr_count = {item.byte_value, stage_reg[4]};

        ent_w     = (stage_reg[0] == 8'd0) ? DIM_FULL : {1'b0, stage_reg[0]};
        ent_h     = (stage_reg[1] == 8'd0) ? DIM_FULL : {1'b0, stage_reg[1]};
        ent_bc    = cursor_reg ? {stage_reg[5], stage_reg[4]}
                               : {stage_reg[7], stage_reg[6]};
        ent_bytes = {stage_reg[11], stage_reg[10], stage_reg[9], stage_reg[8]};
        ent_off   = {item.byte_value, stage_reg[14], stage_reg[13], stage_reg[12]};
        ent_end   = {1'b0, ent_off} + {1'b0, ent_bytes};
        ent_area  = {9'd0, ent_w} * {9'd0, ent_h};
        ent_score = {3'd0, ent_area};
        if (ent_bc >= 16'd32) begin
            ent_score = {3'd0, ent_area} + BONUS_ALPHA;
        end else if (ent_bc >= 16'd24) begin
            ent_score = {3'd0, ent_area} + BONUS_TRUE;
        end else if (ent_bc >= 16'd8) begin
            ent_score = {3'd0, ent_area} + BONUS_INDEX;
        end
        ent_better = ent_score > best_score_reg;
        num_inc    = num_reg + 9'd1;
    end

    always_comb begin
        active       = (phase_reg != PH_DONE);
        hdr_end      = (phase_reg == PH_HEADER)  && (cnt_reg == 4'(HDR_BYTES - 1));
        ent_end_byte = (phase_reg == PH_ENTRIES) && (cnt_reg == 4'(ENT_BYTES - 1));

        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        cursor_next     = cursor_reg;
        total_next      = total_reg;
        num_next        = num_reg;
        best_score_next = best_score_reg;
        best_index_next = best_index_reg;
        best_w_next     = best_w_reg;
        best_h_next     = best_h_reg;
        best_bpp_next   = best_bpp_reg;
        best_bytes_next = best_bytes_reg;
        best_off_next   = best_off_reg;
        emit            = 1'b0;
        st              = ST_OK;

        if (active) begin
            cnt_next = cnt_reg + 4'd1;
        end

        if (hdr_end) begin
            cnt_next = 4'd0;
            if (hdr_rsv != 16'd0 || !(hdr_type inside {TYPE_ICON, TYPE_CURSOR})) begin
                emit = 1'b1;
                st   = ST_BAD_MAGIC;
            end else if (hdr_count == 16'd0 || hdr_count > 16'(MAX_ENTRIES)) begin
                emit = 1'b1;
                st   = ST_COUNT;
            end else begin
                cursor_next = (hdr_type == TYPE_CURSOR);
                total_next  = hdr_count[8:0];
                num_next    = 9'd0;
                phase_next  = PH_ENTRIES;
            end
        end else if (ent_end_byte) begin
            cnt_next = 4'd0;
            if (stage_reg[3] != 8'd0) begin
                emit = 1'b1;
                st   = ST_CORRUPT;
            end else if (ent_end > {1'b0, file_size_reg}) begin
                emit = 1'b1;
                st   = ST_TRUNCATED;
            end else begin
                if (ent_better) begin
                    best_score_next = ent_score;
                    best_index_next = num_reg[7:0];
                    best_w_next     = ent_w;
                    best_h_next     = ent_h;
                    best_bpp_next   = ent_bc;
                    best_bytes_next = ent_bytes;
                    best_off_next   = ent_off;
                end
                num_next = num_inc;
                if (num_inc >= total_reg) begin
                    emit = 1'b1;
                    st   = ST_OK;
                end
            end
        end

        // file ended before a verdict
        if (!emit && item.last_byte && active) begin
            emit = 1'b1;
            st   = ST_TRUNCATED;
        end

        if (emit) begin
            phase_next = PH_DONE;
        end
        if (item.last_byte) begin
            phase_next      = PH_HEADER;
            cnt_next        = 4'd0;
            cursor_next     = 1'b0;
            total_next      = 9'd0;
            num_next        = 9'd0;
            best_score_next = 21'd0;
        end
    end

    assign take      = item_valid && (out_free || !emit);
    assign res_valid = take && emit;

    always_comb begin
        res        = '0;
        res.status = st;
        if (st == ST_OK) begin
            res.pick_index   = best_index_next;
            res.sel_width    = best_w_next;
            res.sel_height   = best_h_next;
            res.pix_depth    = best_bpp_next;
            res.dir_count    = total_reg;
            res.img_len      = best_bytes_next;
            res.entry_offset = best_off_next;
            res.is_cursor    = cursor_reg;
            res.indexed      = (best_bpp_next <= 16'd8);
            res.alpha_flag   = (best_bpp_next >= 16'd32);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            cnt_reg        <= 4'd0;
            cursor_reg     <= 1'b0;
            total_reg      <= 9'd0;
            num_reg        <= 9'd0;
            best_score_reg <= 21'd0;
            file_size_reg  <= 32'd0;
        end else begin
            if (cfg_we) begin
                file_size_reg <= cfg_data;
            end
            if (take) begin
                phase_reg      <= phase_next;
                cnt_reg        <= cnt_next;
                cursor_reg     <= cursor_next;
                total_reg      <= total_next;
                num_reg        <= num_next;
                best_score_reg <= best_score_next;
            end
        end
    end

    // best-entry payload: first entry of every file overwrites it
    always_ff @(posedge aclk) begin
        if (take) begin
            best_index_reg <= best_index_next;
            best_w_reg     <= best_w_next;
            best_h_reg     <= best_h_next;
            best_bpp_reg   <= best_bpp_next;
            best_bytes_reg <= best_bytes_next;
            best_off_reg   <= best_off_next;
            if (active && cnt_reg != 4'(ENT_BYTES - 1)) begin
                stage_reg[cnt_reg] <= item.byte_value;
            end
        end
    end

    a_res_needs_take: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> take && item_valid)
        else $error("result raised without an accepted byte");

    a_err_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status != ST_OK |->
            res.dir_count == 9'd0 && res.sel_width == 9'd0 && res.img_len == 32'd0)
        else $error("error result carries entry fields");

    a_ok_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == ST_OK |->
            res.sel_width != 9'd0 && res.sel_height != 9'd0 && res.dir_count != 9'd0)
        else $error("ok result without a selected entry");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        take && item.last_byte |=>
            phase_reg == PH_HEADER && cnt_reg == 4'd0 && best_score_reg == 21'd0)
        else $error("parser not back at header after last byte");

    a_header_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEADER |-> cnt_reg < 4'(HDR_BYTES))
        else $error("header byte counter overran");

endmodule

FILE: rtl/core/icodir_out_reg.sv
// Result register between the parser and the result channel.
// Depends on icodir_pkg (result_t).
`timescale 1ns / 1ps

module icodir_out_reg
    import icodir_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    output logic    out_free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

FILE: rtl/core/icon_directory_parse_select.sv
// Top level of the icon/cursor directory parser and entry selector.
// Depends on icodir_pkg, icodir_in_reg, icodir_parser, icodir_out_reg.
`timescale 1ns / 1ps
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  s_      | in  | s_valid / s_ready   | s_byte_value[7:0], s_last_byte
//  m_      | out | m_valid / m_ready   | m_status .. m_alpha_flag (one per file)
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_data[31:0] = file size
//
//  One byte transaction per cycle sustained unless a result stalls; a byte is held
//  in the input register; its result (if any) loads the output register when taken.
//  The entry verdict (9x9 area multiply, bonus add, score and bound compares) sits
//  in the single parser stage, which sets the clock period.
//  Reset (aresetn low, synchronous) empties both registers, clears file size to 0
//  and returns the parser to the header.
//  A stalled result transaction holds only bytes that would raise another result;
//  other bytes keep flowing. cfg_ready is always high.

module icon_directory_parse_select
    import icodir_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_pick_index,
    output logic [8:0]  m_sel_width,
    output logic [8:0]  m_sel_height,
    output logic [15:0] m_pix_depth,
    output logic [8:0]  m_dir_count,
    output logic [31:0] m_img_len,
    output logic [31:0] m_entry_offset,
    output logic        m_is_cursor,
    output logic        m_indexed,
    output logic        m_alpha_flag
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    out_free;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign cfg_ready         = 1'b1;
    assign s_item.byte_value = s_byte_value;
    assign s_item.last_byte  = s_last_byte;

    // input register: holds the byte the parser works on; s_ready depends on the parser's take
    icodir_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // header and entry parsing, scoring, best-entry tracking
    icodir_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register feeding the m_ channel
    icodir_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_status       = m_res.status;
    assign m_pick_index   = m_res.pick_index;
    assign m_sel_width    = m_res.sel_width;
    assign m_sel_height   = m_res.sel_height;
    assign m_pix_depth    = m_res.pix_depth;
    assign m_dir_count    = m_res.dir_count;
    assign m_img_len      = m_res.img_len;
    assign m_entry_offset = m_res.entry_offset;
    assign m_is_cursor    = m_res.is_cursor;
    assign m_indexed      = m_res.indexed;
    assign m_alpha_flag   = m_res.alpha_flag;

endmodule

FILE: bench/tb_icon_directory_parse_select.sv
// Self-checking bench for icon_directory_parse_select: random icon and cursor files,
// byte-level prediction of each verdict, and field-by-field checks of every result.
// Depends on icodir_pkg and the RTL under rtl/core; nothing else.
`timescale 1ns / 1ps

module tb_icon_directory_parse_select;
    import icodir_pkg::*;

    // Run shape. Quiet limit covers the long receiver hold-off plus the longest gaps.
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_ITEMS   = 310;
    localparam int unsigned PHASE_FILES   = 6;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned MAX_SHOWN     = 40;

    // Ways of spoiling one directory entry.
    typedef enum int {
        FLAW_NONE,
        FLAW_RESERVED,
        FLAW_BOUNDS
    } flaw_t;

    logic        aclk;
    logic        aresetn          = 1'b0;

    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data         = '0;

    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value     = '0;
    logic        s_last_byte      = 1'b0;

    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [2:0]  m_status;
    logic [7:0]  m_pick_index;
    logic [8:0]  m_sel_width;
    logic [8:0]  m_sel_height;
    logic [15:0] m_pix_depth;
    logic [8:0]  m_dir_count;
    logic [31:0] m_img_len;
    logic [31:0] m_entry_offset;
    logic        m_is_cursor;
    logic        m_indexed;
    logic        m_alpha_flag;

    icon_directory_parse_select i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_value   (s_byte_value),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_pick_index   (m_pick_index),
        .m_sel_width    (m_sel_width),
        .m_sel_height   (m_sel_height),
        .m_pix_depth    (m_pix_depth),
        .m_dir_count    (m_dir_count),
        .m_img_len      (m_img_len),
        .m_entry_offset (m_entry_offset),
        .m_is_cursor    (m_is_cursor),
        .m_indexed      (m_indexed),
        .m_alpha_flag   (m_alpha_flag)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Bench-side copy of the parser: state of the file in progress, the
    // best entry so far and the file size register.
    // ------------------------------------------------------------------
    phase_t      parse_state = PH_HEADER;
    logic [7:0]  stage_bytes [16];
    int unsigned rec_pos     = 0;
    logic        cursor_seen = 1'b0;
    logic [8:0]  dir_total   = '0;
    logic [8:0]  dir_index   = '0;
    int unsigned top_score   = 0;
    logic [7:0]  top_index   = '0;
    logic [8:0]  top_w       = '0;
    logic [8:0]  top_h       = '0;
    logic [15:0] top_bpp     = '0;
    logic [31:0] top_len     = '0;
    logic [31:0] top_off     = '0;
    logic [31:0] size_limit  = '0;

    result_t     verdict_q [$];     // verdicts owed by the block, oldest first
    item_t       byte_q [$];        // bytes waiting for the driver

    // Generator state
    logic [7:0]  img [$];           // file under construction
    logic [7:0]  prev_entry [16];
    logic        have_prev   = 1'b0;
    logic        cursor_file = 1'b0;
    logic [31:0] phase_limit = '0;
    int unsigned items_sent  = 0;
    int unsigned files_sent  = 0;

    // Idling controls, written by the stimulus process only between phases
    logic        tx_gap_on   = 1'b1;
    logic        rx_stall_on = 1'b1;

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned quiet_cycles   = 0;

    // One byte accepted by the block: advance the parser copy and queue any verdict.
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        logic        fire;
        status_t     st;
        logic [15:0] rsv;
        logic [15:0] kind;
        logic [15:0] cnt;
        logic [15:0] bc;
        logic [8:0]  w;
        logic [8:0]  h;
        logic [31:0] len;
        logic [31:0] off;
        int unsigned score;
        result_t     res;
        fire = 1'b0;
        st   = ST_OK;
        case (parse_state)
            PH_HEADER: begin
                stage_bytes[rec_pos] = b;
                rec_pos++;
                if (rec_pos == HDR_BYTES) begin
                    rec_pos = 0;
                    rsv  = {stage_bytes[1], stage_bytes[0]};
                    kind = {stage_bytes[3], stage_bytes[2]};
                    cnt  = {stage_bytes[5], stage_bytes[4]};
                    if (rsv != 0 || (kind != TYPE_ICON && kind != TYPE_CURSOR)) begin
                        fire = 1'b1;
                        st   = ST_BAD_MAGIC;
                    end else if (cnt == 0 || cnt > MAX_ENTRIES) begin
                        fire = 1'b1;
                        st   = ST_COUNT;
                    end else begin
                        cursor_seen = (kind == TYPE_CURSOR);
                        dir_total   = cnt[8:0];
                        dir_index   = '0;
                        parse_state = PH_ENTRIES;
                    end
                end
            end
            PH_ENTRIES: begin
                stage_bytes[rec_pos] = b;
                rec_pos++;
                if (rec_pos == ENT_BYTES) begin
                    rec_pos = 0;
                    w   = (stage_bytes[0] == 0) ? DIM_FULL : {1'b0, stage_bytes[0]};
                    h   = (stage_bytes[1] == 0) ? DIM_FULL : {1'b0, stage_bytes[1]};
                    // cursors keep the bit count where icons keep the planes
                    bc  = cursor_seen ? {stage_bytes[5], stage_bytes[4]}
                                      : {stage_bytes[7], stage_bytes[6]};
                    len = {stage_bytes[11], stage_bytes[10], stage_bytes[9], stage_bytes[8]};
                    off = {stage_bytes[15], stage_bytes[14], stage_bytes[13], stage_bytes[12]};
                    if (stage_bytes[3] != 0) begin
                        fire = 1'b1;
                        st   = ST_CORRUPT;
                    end else if ({1'b0, off} + {1'b0, len} > {1'b0, size_limit}) begin
                        fire = 1'b1;
                        st   = ST_TRUNCATED;
                    end else begin
                        score = 32'(w) * 32'(h);
                        if (bc >= 32)
                            score += 32'(BONUS_ALPHA);
                        else if (bc >= 24)
                            score += 32'(BONUS_TRUE);
                        else if (bc >= 8)
                            score += 32'(BONUS_INDEX);
                        // strictly greater: the first of equal entries wins
                        if (score > top_score) begin
                            top_score = score;
                            top_index = dir_index[7:0];
                            top_w     = w;
                            top_h     = h;
                            top_bpp   = bc;
                            top_len   = len;
                            top_off   = off;
                        end
                        dir_index++;
                        if (dir_index >= dir_total)
                            fire = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // a last byte that ends the file early owes a truncated verdict
        if (!fire && last && parse_state != PH_DONE) begin
            fire = 1'b1;
            st   = ST_TRUNCATED;
        end
        if (fire) begin
            res        = '0;
            res.status = st;
            if (st == ST_OK) begin
                res.pick_index   = top_index;
                res.sel_width    = top_w;
                res.sel_height   = top_h;
                res.pix_depth    = top_bpp;
                res.dir_count    = dir_total;
                res.img_len      = top_len;
                res.entry_offset = top_off;
                res.is_cursor    = cursor_seen;
                res.indexed      = (top_bpp <= 8);
                res.alpha_flag   = (top_bpp >= 32);
            end
            verdict_q.push_back(res);
        end
        if (last) begin
            parse_state = PH_HEADER;
            rec_pos     = 0;
            foreach (stage_bytes[i])
                stage_bytes[i] = '0;
            cursor_seen = 1'b0;
            dir_total   = '0;
            dir_index   = '0;
            top_score   = 0;
            top_index   = '0;
            top_w       = '0;
            top_h       = '0;
            top_bpp     = '0;
            top_len     = '0;
            top_off     = '0;
        end else if (fire) begin
            parse_state = PH_DONE;
        end
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_count < MAX_SHOWN)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                    results_seen, name, got, want));
    endtask

    // Mostly back to back, now and then a short gap, rarely a long gap.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic logic [15:0] pick_depth();
        logic [15:0] depths [12] = '{16'd0, 16'd1, 16'd4, 16'd7, 16'd8, 16'd16,
                                     16'd23, 16'd24, 16'd31, 16'd32, 16'd33, 16'd64};
        int unsigned r;
        r = $urandom_range(13, 0);
        if (r < 12)
            return depths[r];
        return 16'($urandom);
    endfunction

    task automatic put16(input logic [15:0] v);
        img.push_back(v[7:0]);
        img.push_back(v[15:8]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endtask

    // One 16-byte directory entry, in bounds unless a flaw is asked for.
    task automatic add_entry(input flaw_t flaw);
        logic [7:0]  e [16];
        logic [15:0] bc;
        logic [31:0] off;
        logic [31:0] len;
        if (have_prev && flaw == FLAW_NONE && $urandom_range(99, 0) < 12) begin
            e = prev_entry;     // duplicate, to tie on score
        end else begin
            e[0] = ($urandom_range(9, 0) == 0) ? 8'd0 : 8'($urandom);
            e[1] = ($urandom_range(9, 0) == 0) ? 8'd0 : 8'($urandom);
            e[2] = 8'($urandom);
            e[3] = 8'd0;
            bc   = pick_depth();
            if (cursor_file) begin
                {e[5], e[4]} = bc;
                {e[7], e[6]} = 16'($urandom);
            end else begin
                {e[5], e[4]} = 16'($urandom);
                {e[7], e[6]} = bc;
            end
            off = $urandom_range(phase_limit, 0);
            len = $urandom_range(phase_limit - off, 0);
            {e[11], e[10], e[9], e[8]}   = len;
            {e[15], e[14], e[13], e[12]} = off;
        end
        if (flaw == FLAW_RESERVED) begin
            e[3] = 8'($urandom_range(255, 1));
        end else if (flaw == FLAW_BOUNDS) begin
            if (phase_limit == 32'hFFFF_FFFF) begin
                // only the carry out of the 32-bit sum can break this bound
                off = $urandom_range(32'hFFFF_FFFF, 1);
                len = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFFF - off + 1);
            end else begin
                off = $urandom;
                if (off > phase_limit)
                    len = $urandom;
                else if ($urandom_range(2, 0) == 0)
                    len = phase_limit - off + 1;
                else
                    len = $urandom_range(32'hFFFF_FFFF, phase_limit - off + 1);
            end
            {e[11], e[10], e[9], e[8]}   = len;
            {e[15], e[14], e[13], e[12]} = off;
        end
        prev_entry = e;
        have_prev  = 1'b1;
        foreach (e[i])
            img.push_back(e[i]);
    endtask

    // Hand the built file to the driver, flagging its final byte.
    task automatic ship();
        foreach (img[i])
            byte_q.push_back('{byte_value: img[i], last_byte: (i == img.size() - 1)});
        items_sent += img.size();
        files_sent++;
    endtask

    task automatic one_file();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        int unsigned cut;
        int unsigned extra;
        logic [15:0] kind;
        logic [15:0] rsv;
        logic [15:0] hdr_cnt;
        img.delete();
        have_prev   = 1'b0;
        cursor_file = 1'($urandom_range(1, 0));
        kind  = cursor_file ? TYPE_CURSOR : TYPE_ICON;
        n     = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 4) : $urandom_range(3, 1);
        extra = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(4, 1);
        pick  = $urandom_range(99, 0);
        if (pick < 60) begin
            // complete directory, possibly followed by ignored image bytes
            put16(16'd0);
            put16(kind);
            put16(16'(n));
            repeat (n) add_entry(FLAW_NONE);
            repeat (extra) img.push_back(8'($urandom));
        end else if (pick < 77) begin
            // one spoilt entry ends the directory
            k = $urandom_range(n - 1, 0);
            put16(16'd0);
            put16(kind);
            put16(16'(n));
            repeat (k) add_entry(FLAW_NONE);
            add_entry((pick < 69) ? FLAW_RESERVED : FLAW_BOUNDS);
            repeat (extra) img.push_back(8'($urandom));
        end else if (pick < 86) begin
            // file ends before the directory does; sometimes a full 256-entry header
            hdr_cnt = ($urandom_range(4, 0) == 0) ? 16'(MAX_ENTRIES) : 16'(n);
            put16(16'd0);
            put16(kind);
            put16(hdr_cnt);
            repeat (n) add_entry(FLAW_NONE);
            cut = (hdr_cnt == n) ? $urandom_range(img.size() - 1, 1)
                                 : $urandom_range(img.size(), 1);
            while (img.size() > cut)
                void'(img.pop_back());
        end else if (pick < 92) begin
            if ($urandom_range(1, 0) == 1) begin
                rsv = 16'($urandom_range(16'hFFFF, 1));
            end else begin
                rsv  = 16'd0;
                kind = 16'($urandom);
                if (kind == TYPE_ICON || kind == TYPE_CURSOR)
                    kind = ($urandom_range(1, 0) == 1) ? 16'd3 : 16'd0;
            end
            put16(rsv);
            put16(kind);
            put16(16'(n));
            repeat ($urandom_range(8, 0)) img.push_back(8'($urandom));
        end else if (pick < 97) begin
            case ($urandom_range(2, 0))
                0:       hdr_cnt = 16'd0;
                1:       hdr_cnt = 16'(MAX_ENTRIES + 1);
                default: hdr_cnt = 16'($urandom_range(16'hFFFF, MAX_ENTRIES + 1));
            endcase
            put16(16'd0);
            put16(kind);
            put16(hdr_cnt);
            repeat ($urandom_range(8, 0)) img.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(20, 1)) img.push_back(8'($urandom));
        end
        ship();
    endtask

    // Writes happen only with the byte channel drained and nothing owed.
    task automatic set_file_size(input logic [31:0] v);
        phase_limit = v;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        size_limit = v;
        cfg_valid <= 1'b0;
    endtask

    // Sender pause: every byte taken, every verdict back, then an idle settling wait.
    task automatic settle();
        while (byte_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: predicts on each accepted transaction, then offers the
    // next queued byte, with random gaps between transactions while tx_gap_on is set.
    // ------------------------------------------------------------------
    item_t       tx_item;
    int unsigned tx_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  = 0;
        end else begin
            if (s_valid && s_ready)
                absorb_byte(s_byte_value, s_last_byte);
            // a byte still on offer stays put until taken
            if (!(s_valid && !s_ready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    tx_item = byte_q.pop_front();
                    s_valid      <= 1'b1;
                    s_byte_value <= tx_item.byte_value;
                    s_last_byte  <= tx_item.last_byte;
                    tx_gap = tx_gap_on ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each result transaction against the oldest
    // owed verdict and drives m_ready. Up to twice in the run it holds off,
    // starting while bytes are still queued, so the block backs up and
    // drops s_ready.
    // ------------------------------------------------------------------
    result_t     want;
    int unsigned hold_left  = 0;
    int unsigned holds_done = 0;
    int unsigned rx_wait    = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    note_mismatch($sformatf("result %0d arrived with none owed", results_seen));
                end else begin
                    want = verdict_q.pop_front();
                    check_field("status",       m_status,       want.status);
                    check_field("pick_index",   m_pick_index,   want.pick_index);
                    check_field("sel_width",    m_sel_width,    want.sel_width);
                    check_field("sel_height",   m_sel_height,   want.sel_height);
                    check_field("pix_depth",    m_pix_depth,    want.pix_depth);
                    check_field("dir_count",    m_dir_count,    want.dir_count);
                    check_field("img_len",      m_img_len,      want.img_len);
                    check_field("entry_offset", m_entry_offset, want.entry_offset);
                    check_field("is_cursor",    m_is_cursor,    want.is_cursor);
                    check_field("indexed",      m_indexed,      want.indexed);
                    check_field("alpha_flag",   m_alpha_flag,   want.alpha_flag);
                end
            end
            if (hold_left == 0 && holds_done < 2 && byte_q.size() > 80 &&
                results_seen >= ((holds_done == 0) ? 8 : 30)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else if (rx_stall_on && $urandom_range(99, 0) < 30) begin
                rx_wait = pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transaction on any channel ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: header-level corner files first, then five random phases,
    // each with its own file size and idling mix. Between phases the
    // sender waits for every verdict before the register is rewritten.
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        set_file_size(32'd4096);

        // nonzero reserved word, flagged last on the sixth byte
        img.delete();
        put16(16'h0001);
        put16(TYPE_ICON);
        put16(16'd1);
        ship();
        // unknown type, then an ignored byte carrying the last flag
        img.delete();
        put16(16'h0000);
        put16(16'h0003);
        put16(16'd1);
        img.push_back(8'hFF);
        ship();
        // empty directory
        img.delete();
        put16(16'h0000);
        put16(TYPE_ICON);
        put16(16'd0);
        ship();
        // one entry too many
        img.delete();
        put16(16'h0000);
        put16(TYPE_CURSOR);
        put16(16'(MAX_ENTRIES + 1));
        ship();
        // lone last byte
        img.delete();
        img.push_back(8'hFF);
        ship();
        settle();

        for (int p = 0; p < 5; p++) begin
            int unsigned item_mark;
            int unsigned file_mark;
            // phase 1 runs without idling on either side
            tx_gap_on   = (p != 1 && p != 3);
            rx_stall_on = (p != 1 && p != 2);
            case (p)
                0:       set_file_size(32'hFFFF_FFFF);
                1:       set_file_size(32'd0);
                2:       set_file_size($urandom);
                3:       set_file_size(32'd65535);
                default: set_file_size($urandom_range(3000, 1));
            endcase
            item_mark = items_sent;
            file_mark = files_sent;
            while (items_sent - item_mark < PHASE_ITEMS || files_sent - file_mark < PHASE_FILES)
                one_file();
            settle();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
